// ===== rtl/gbfs_pkg.sv =====
`default_nettype none
package gbfs_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int POS_W    = ROW_W + COL_W;
  localparam int DIM_W    = 5;
  localparam int DIST_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);
  localparam logic [DIST_W-1:0]    DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_EXIT  = 2'd0,
    KIND_OPEN  = 2'd1,
    KIND_WALL  = 2'd2,
    KIND_START = 2'd3
  } cell_kind_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_INIT,
    ST_SEARCH
  } state_t;

  // broadcast controls for every cell of the array
  typedef struct packed {
    logic load;   // a grid cell code is being written this cycle
    logic init;   // seed the wave from the start cell
    logic step;   // advance the wave one distance step
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/grid_bfs_shortest_path_core.sv =====
`default_nettype none
// Grid shortest path by breadth-first wavefront. Pulse start with in_cell_kind
// once per cell, row-major, one request per cycle while busy is low; a grid is
// cfg rows x cfg cols (0 acts as 1, above 16 as 16). A write to either config
// register restarts loading. After the last cell, busy rises for the seed
// state ST_INIT, then stays high in ST_SEARCH while the wave examines levels
// (up to the exit distance, or the depth of the reachable region); the step
// rate is set by the array of per-cell wave registers, which advance one step
// a cycle. The result appears for exactly one cycle with out_valid:
// out_distance and out_reachable. The receiver cannot stall it. busy drops in
// the same cycle that out_valid rises, so the next grid can start right away.
module grid_bfs_shortest_path_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_cell_kind,
  output logic                                out_valid,
  output logic [gbfs_pkg::DIST_W-1:0]         out_distance,
  output logic                                out_reachable,
  input  wire logic                           cfg_we,
  input  wire logic [gbfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gbfs_pkg::DIM_W-1:0]     cfg_wdata
);
  import gbfs_pkg::*;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0]  rows_r, cols_r, rows_eff, cols_eff;
  logic [ROW_W-1:0]  ld_row_r, ld_row_nxt;
  logic [COL_W-1:0]  ld_col_r, ld_col_nxt;
  logic [POS_W-1:0]  start_pos_r, start_pos_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic              out_reach_r, out_reach_nxt;

  logic              accept, last_cell, cfg_hit;
  logic              any_hit, any_new;
  cell_ctrl_t        ctrl;
  logic [CELLS-1:0]  front_w, hit_w, new_w;

  assign accept  = start && !busy;
  assign busy    = (state_r != ST_LOAD);
  assign cfg_hit = cfg_we && ((cfg_index == REG_ROWS) || (cfg_index == REG_COLS));

  // clamp dimensions into 1..MAX
  always_comb begin
    if (rows_r == '0)                     rows_eff = DIM_W'(1);
    else if (rows_r > DIM_W'(MAX_ROWS))   rows_eff = DIM_W'(MAX_ROWS);
    else                                  rows_eff = rows_r;
    if (cols_r == '0)                     cols_eff = DIM_W'(1);
    else if (cols_r > DIM_W'(MAX_COLS))   cols_eff = DIM_W'(MAX_COLS);
    else                                  cols_eff = cols_r;
  end

  assign last_cell = (DIM_W'(ld_row_r) == rows_eff - DIM_W'(1)) &&
                     (DIM_W'(ld_col_r) == cols_eff - DIM_W'(1));

  assign any_hit = |hit_w;
  assign any_new = |new_w;

  always_comb begin
    state_nxt     = state_r;
    ld_row_nxt    = ld_row_r;
    ld_col_nxt    = ld_col_r;
    start_pos_nxt = start_pos_r;
    dist_nxt      = dist_r;
    out_valid_nxt = 1'b0;
    out_dist_nxt  = out_dist_r;
    out_reach_nxt = out_reach_r;
    ctrl          = '0;
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          ctrl.load = 1'b1;
          if (in_cell_kind == KIND_START) start_pos_nxt = {ld_row_r, ld_col_r};
          if (last_cell) begin
            ld_row_nxt = '0;
            ld_col_nxt = '0;
            state_nxt  = ST_INIT;
          end else if (DIM_W'(ld_col_r) == cols_eff - DIM_W'(1)) begin
            ld_col_nxt = '0;
            ld_row_nxt = ld_row_r + ROW_W'(1);
          end else begin
            ld_col_nxt = ld_col_r + COL_W'(1);
          end
        end
        if (cfg_hit) begin
          ld_row_nxt    = '0;
          ld_col_nxt    = '0;
          start_pos_nxt = '0;
        end
      end
      ST_INIT: begin
        ctrl.init     = 1'b1;
        start_pos_nxt = '0;
        dist_nxt      = '0;
        state_nxt     = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (any_hit) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = dist_r;
          out_reach_nxt = 1'b1;
          state_nxt     = ST_LOAD;
        end else if (!any_new) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = '0;
          out_reach_nxt = 1'b0;
          state_nxt     = ST_LOAD;
        end else begin
          ctrl.step = 1'b1;
          if (dist_r != DIST_MAX) dist_nxt = dist_r + DIST_W'(1);
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      rows_r      <= DIM_W'(MAX_ROWS);
      cols_r      <= DIM_W'(MAX_COLS);
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      start_pos_r <= '0;
      dist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ld_row_r    <= ld_row_nxt;
      ld_col_r    <= ld_col_nxt;
      start_pos_r <= start_pos_nxt;
      dist_r      <= dist_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == REG_ROWS) rows_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_COLS) cols_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    out_dist_r  <= out_dist_nxt;
    out_reach_r <= out_reach_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_distance  = out_dist_r;
  assign out_reachable = out_reach_r;

  // cell array: each cell passes its wave bit to its neighbors (up to four)
  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
    for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
      localparam int P = r * MAX_COLS + c;
      logic nb;
      logic in_grid;
      always_comb begin
        nb = 1'b0;
        if (r > 0)            nb = nb | front_w[(r > 0 ? P - MAX_COLS : P)];
        if (r < MAX_ROWS - 1) nb = nb | front_w[(r < MAX_ROWS - 1 ? P + MAX_COLS : P)];
        if (c > 0)            nb = nb | front_w[(c > 0 ? P - 1 : P)];
        if (c < MAX_COLS - 1) nb = nb | front_w[(c < MAX_COLS - 1 ? P + 1 : P)];
      end
      assign in_grid = (DIM_W'(r) < rows_eff) && (DIM_W'(c) < cols_eff);

      gbfs_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sel_load  ({ld_row_r, ld_col_r} == POS_W'(P)),
        .load_kind (in_cell_kind),
        .is_start  (start_pos_r == POS_W'(P)),
        .in_grid   (in_grid),
        .nb_front  (nb),
        .front_o   (front_w[P]),
        .hit_o     (hit_w[P]),
        .new_o     (new_w[P])
      );
    end
  end

`ifndef SYNTH
  a_out_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_SEARCH))
    else $error("result without search");
  a_init_to_search: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INIT |=> state_r == ST_SEARCH)
    else $error("seed cycle not followed by search");
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reachable |-> out_distance == '0)
    else $error("unreachable with nonzero distance");
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_cell |=> busy)
    else $error("not busy after last cell");
`endif

endmodule
`default_nettype wire

// ===== rtl/gbfs_cell.sv =====
`default_nettype none
module gbfs_cell (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire gbfs_pkg::cell_ctrl_t  ctrl,
  input  wire logic                  sel_load,
  input  wire logic [1:0]            load_kind,
  input  wire logic                  is_start,
  input  wire logic                  in_grid,
  input  wire logic                  nb_front,
  output logic                       front_o,
  output logic                       hit_o,
  output logic                       new_o
);
  import gbfs_pkg::*;

  logic [1:0] kind_r;
  logic       visited_r, visited_nxt;
  logic       front_r, front_nxt;
  logic       is_wall;

  assign is_wall = (kind_r == KIND_WALL);
  assign new_o   = in_grid && nb_front && !visited_r && !is_wall;
  assign front_o = front_r;
  assign hit_o   = front_r && (kind_r == KIND_EXIT);

  always_comb begin
    visited_nxt = visited_r;
    front_nxt   = front_r;
    if (ctrl.init) begin
      visited_nxt = is_start && !is_wall;
      front_nxt   = is_start && !is_wall;
    end else if (ctrl.step) begin
      visited_nxt = visited_r | new_o;
      front_nxt   = new_o;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && sel_load) begin
      kind_r <= load_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= 1'b0;
      front_r   <= 1'b0;
    end else begin
      visited_r <= visited_nxt;
      front_r   <= front_nxt;
    end
  end

endmodule
`default_nettype wire
